[src/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths, types and register indexes of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int VALUE_BITS = 31;
  // bit counter covers 0 .. VALUE_BITS-1
  localparam int CNT_W      = $clog2(VALUE_BITS);
  // signed working width: holds 2*acc + a, which stays below 3*modulus
  localparam int ACC_W      = VALUE_BITS + 3;
  localparam int CFG_IDX_W  = 1;

  typedef logic [VALUE_BITS-1:0]   word_t;
  typedef logic signed [ACC_W-1:0] wide_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  localparam cfg_idx_t CFG_EXPONENT = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_MODULUS  = cfg_idx_t'(1);

  // request to the modular multiplier: a * b mod m, with a < m
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mm_req_t;

  // response from the modular multiplier
  typedef struct packed {
    logic  done;
    word_t product;
  } mm_rsp_t;

endpackage

[src/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial shift-add modular multiplier
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic            clk,
  input  logic            rst_n,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);
  import mexp_pkg::*;

  logic  busy_r, busy_nxt;
  logic  prep_r, prep_nxt;
  logic  done_r, done_nxt;
  cnt_t  cnt_r, cnt_nxt;
  word_t acc_r, acc_nxt;
  word_t b_sh_r, b_sh_nxt;
  word_t a_r, a_nxt;
  word_t m_r, m_nxt;
  wide_t amm_r, amm_nxt;   // a - m
  wide_t am2_r, am2_nxt;   // a - 2m

  wide_t x_w, a_w, m_w;
  wide_t n1, d0, d1, d2, sel;

  always_comb begin
    x_w = {2'b00, acc_r, 1'b0};
    a_w = {3'b000, a_r};
    m_w = {3'b000, m_r};
    n1  = x_w - m_w;
    d0  = x_w + a_w;
    d1  = x_w + amm_r;
    d2  = x_w + am2_r;
    // 2*acc + bit*a lies below 3m: pick the candidate that is non-negative
    if (b_sh_r[VALUE_BITS-1]) begin
      if (!d2[ACC_W-1]) begin
        sel = d2;
      end else if (!d1[ACC_W-1]) begin
        sel = d1;
      end else begin
        sel = d0;
      end
    end else begin
      sel = n1[ACC_W-1] ? x_w : n1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    prep_nxt = prep_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    b_sh_nxt = b_sh_r;
    a_nxt    = a_r;
    m_nxt    = m_r;
    amm_nxt  = amm_r;
    am2_nxt  = am2_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      prep_nxt = 1'b1;
      cnt_nxt  = cnt_t'(VALUE_BITS - 1);
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_sh_nxt = req.b;
      m_nxt    = req.m;
    end else if (prep_r) begin
      prep_nxt = 1'b0;
      amm_nxt  = a_w - m_w;
      am2_nxt  = a_w - {m_w[ACC_W-2:0], 1'b0};
    end else if (busy_r) begin
      acc_nxt  = sel[VALUE_BITS-1:0];
      b_sh_nxt = {b_sh_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt  = cnt_r - cnt_t'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      prep_r <= prep_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    b_sh_r <= b_sh_nxt;
    a_r    <= a_nxt;
    m_r    <= m_nxt;
    amm_r  <= amm_nxt;
    am2_r  <= am2_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

  // accumulator stays reduced while a product is formed
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !prep_r) |-> (acc_r < m_r))
    else $error("mulmod accumulator not below modulus");

  // finished product is a residue
  a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < m_r))
    else $error("mulmod product not below modulus");

  // done comes in the cycle after the last bit step
  a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("mulmod done without a finished step");

endmodule

[src/modular_exponentiation_top.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// value ^ exponent mod modulus by right-to-left square and multiply
// ----------------------------------------------------------------------------
// usage:
//   cfg_we/cfg_index/cfg_data write exponent (index 0) and modulus (index 1);
//   write them only while the block is idle. reset sets exponent 1, modulus 2.
//   input channel in_valid/in_stall/in_value: one transfer per word; in_stall
//   stays high while a word is being worked on.
//   output channel out_valid/out_stall/out_residue: one residue per word,
//   held in an output register, so the next word is taken while a finished
//   residue still waits for the receiver.
// arithmetic:
//   every modular product goes through one bit-serial multiplier (issue,
//   setup, 31 bit steps, done). a word needs one reduction of the base,
//   31 squarings and one multiply per set exponent bit. a modulus below 2
//   gives residue 0 with no multiplication.
// reset: synchronous active low rst_n, clears control; no result pending.
// stall: a waiting residue holds; the sequencer then holds its finished
//   result until the output register frees up.
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  mexp_pkg::cfg_idx_t cfg_index,
  input  mexp_pkg::word_t    cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  mexp_pkg::word_t    in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output mexp_pkg::word_t    out_residue
);
  import mexp_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_MUL    = 5'b00100,
    S_SQR    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  word_t   exponent_r, exponent_nxt;
  word_t   modulus_r, modulus_nxt;
  word_t   exp_sh_r, exp_sh_nxt;   // exponent bits still to scan, lsb first
  word_t   base_r, base_nxt;       // running base, raw input during reduction
  word_t   res_r, res_nxt;         // running result
  word_t   mod_r, mod_nxt;         // modulus of the word in flight
  cnt_t    bit_r, bit_nxt;         // exponent bit being scanned
  logic    issued_r, issued_nxt;   // multiplier request outstanding
  logic    out_valid_r, out_valid_nxt;
  word_t   out_residue_r, out_residue_nxt;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  logic    in_xfer, out_xfer, out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  // operand selection for the shared multiplier
  always_comb begin
    mm_req.start = 1'b0;
    mm_req.a     = base_r;
    mm_req.b     = base_r;
    mm_req.m     = mod_r;
    case (state_r)
      S_REDUCE: begin
        // value mod m as 1 * value mod m
        mm_req.start = !issued_r;
        mm_req.a     = word_t'(1);
      end
      S_MUL: begin
        mm_req.start = !issued_r;
        mm_req.a     = res_r;
      end
      S_SQR: begin
        mm_req.start = !issued_r;
      end
      default: begin
        mm_req.start = 1'b0;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_comb begin
    state_nxt       = state_r;
    exponent_nxt    = exponent_r;
    modulus_nxt     = modulus_r;
    exp_sh_nxt      = exp_sh_r;
    base_nxt        = base_r;
    res_nxt         = res_r;
    mod_nxt         = mod_r;
    bit_nxt         = bit_r;
    issued_nxt      = issued_r;
    out_valid_nxt   = out_valid_r && !out_xfer;
    out_residue_nxt = out_residue_r;

    // register writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_EXPONENT: exponent_nxt = cfg_data;
        CFG_MODULUS:  modulus_nxt  = cfg_data;
        default:      exponent_nxt = exponent_r;
      endcase
    end

    if (mm_req.start) begin
      issued_nxt = 1'b1;
    end
    if (mm_rsp.done) begin
      issued_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          exp_sh_nxt = exponent_r;
          base_nxt   = in_value;
          res_nxt    = word_t'(1);
          mod_nxt    = modulus_r;
          bit_nxt    = '0;
          // modulus zero or one: residue is 0, no arithmetic
          if (modulus_r < word_t'(2)) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mm_rsp.done) begin
          base_nxt  = mm_rsp.product;
          state_nxt = exp_sh_r[0] ? S_MUL : S_SQR;
        end
      end
      S_MUL: begin
        if (mm_rsp.done) begin
          res_nxt   = mm_rsp.product;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          base_nxt   = mm_rsp.product;
          exp_sh_nxt = exp_sh_r >> 1;
          bit_nxt    = bit_r + cnt_t'(1);
          if (bit_r == cnt_t'(VALUE_BITS - 1)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = exp_sh_r[1] ? S_MUL : S_SQR;
          end
        end
      end
      S_DONE: begin
        // hand the residue to the output register once it is free
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_residue_nxt = res_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exponent_r  <= word_t'(1);
      modulus_r   <= word_t'(2);
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exponent_r  <= exponent_nxt;
      modulus_r   <= modulus_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
    exp_sh_r      <= exp_sh_nxt;
    base_r        <= base_nxt;
    res_r         <= res_nxt;
    mod_r         <= mod_nxt;
    bit_r         <= bit_nxt;
    out_residue_r <= out_residue_nxt;
  end

  // busy while a word is in flight
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

  // running values stay residues during the exponent scan
  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_SQR) |-> (res_r < mod_r && base_r < mod_r))
    else $error("exponent scan operand not below modulus");

  // multiplier only answers while the sequencer waits for it
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (issued_r &&
      (state_r == S_REDUCE || state_r == S_MUL || state_r == S_SQR)))
    else $error("multiplier result without a pending request");

  // a finished residue is never dropped onto a waiting one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(out_residue_r) && out_valid_r))
    else $error("waiting residue overwritten");

endmodule
